### rtl/fdr_pkg.sv
// fresnel dielectric reflectance: shared widths and constants
// no dependencies
package fdr_pkg;

    localparam int COS_W   = 16;
    localparam int ETA_W   = 14;
    localparam int REFL_W  = 16;
    localparam int AC_W    = 15;
    localparam int ACSQ_W  = 29;
    localparam int ETASQ_W = 28;
    localparam int LHS_W   = 57;
    localparam int RAD_W   = 56;
    localparam int ROOT_W  = 28;
    localparam int REM_W   = 30;
    localparam int SA_W    = 42;
    localparam int PA_W    = 28;
    localparam int SD_W    = 43;
    localparam int PD_W    = 29;
    localparam int SN_W    = 60;
    localparam int PN_W    = 46;
    localparam int Q_W     = 17;
    localparam int RSQ_W   = 33;
    localparam int SUM_W   = 34;
    localparam int FRAC_SH = 16;
    localparam int SQ_SH   = 18;
    localparam int SQRT_SIDE_W = 1 + ETA_W + SA_W + PA_W;

    localparam logic signed [COS_W-1:0] ONE_Q14     = 16'sd16384;
    localparam logic signed [COS_W-1:0] NEG_ONE_Q14 = -16'sd16384;
    localparam logic [REFL_W-1:0]       ONE_Q15     = 16'd32768;
    localparam logic [Q_W-1:0]          RATIO_ONE   = 17'd65536;

endpackage

### rtl/fdr_if.sv
// stream interfaces for the reflectance block
// depends on fdr_pkg
interface fdr_in_if;
    logic                                valid;
    logic                                ready;
    logic signed [fdr_pkg::COS_W-1:0]    cos_incident;
    logic        [fdr_pkg::ETA_W-1:0]    eta_incident;
    logic        [fdr_pkg::ETA_W-1:0]    eta_transmitted;

    modport source (output valid, cos_incident, eta_incident, eta_transmitted, input ready);
    modport sink (input valid, cos_incident, eta_incident, eta_transmitted, output ready);
endinterface

interface fdr_out_if;
    logic                                valid;
    logic                                ready;
    logic [fdr_pkg::REFL_W-1:0]          reflectance;

    modport source (output valid, reflectance, input ready);
    modport sink (input valid, reflectance, output ready);
endinterface

### rtl/fresnel_dielectric_reflectance.sv
// Unpolarized Fresnel reflectance of a dielectric boundary, fully pipelined.
// One item is taken every cycle while the chain is not stalled. The path is 4 setup stages, a
// 28-cell square root chain, 2 stages to form the ratios, two 17-cell divider
// chains side by side, one squaring stage, then a 2-beat output buffer. The
// whole chain advances together and stops only when that buffer is full.
// depends on fdr_pkg, fdr_if, fdr_sqrt_cell, fdr_div_cell
module fresnel_dielectric_reflectance (
    input  logic        i_clk,
    input  logic        i_rst_n,
    fdr_in_if.sink      i_in,
    fdr_out_if.source   o_out
);
    import fdr_pkg::*;

    logic w_en;
    logic w_push;
    logic w_pop;

    // setup stages
    logic               r_v1, r_v2, r_v3, r_v4, r_v5, r_v6, r_v7;
    logic [AC_W-1:0]    r_ac1, r_ac2, r_ac3;
    logic [ETA_W-1:0]   r_ei1, r_et1, r_ei2, r_ei3, r_ei4;
    logic [ACSQ_W-1:0]  r_acsq2;
    logic [ETASQ_W-1:0] r_eisq2, r_etsq2, r_etsq3;
    logic [LHS_W-1:0]   r_lhs3;
    logic               r_tir4;
    logic [RAD_W-1:0]   r_rad4;
    logic [SA_W-1:0]    r_sa4;
    logic [PA_W-1:0]    r_pa4;

    logic signed [COS_W-1:0] w_c;
    logic [AC_W-1:0]    w_ac;
    logic [LHS_W-1:0]   w_rhs;
    logic [ACSQ_W-1:0]  w_s2;
    logic               w_tir;

    always_comb begin
        w_c = i_in.cos_incident;
        if (w_c > ONE_Q14) begin
            w_c = ONE_Q14;
        end else if (w_c < NEG_ONE_Q14) begin
            w_c = NEG_ONE_Q14;
        end
        w_ac  = w_c[COS_W-1] ? AC_W'(-w_c) : AC_W'(w_c);
        w_s2  = (ACSQ_W'(1) << 28) - r_acsq2;
        w_rhs = LHS_W'(r_etsq3) << 28;
        w_tir = r_lhs3 >= w_rhs;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else if (w_en) begin
            r_v1 <= i_in.valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_ac1   <= w_ac;
            r_ei1   <= i_in.eta_incident;
            r_et1   <= i_in.eta_transmitted;
            r_acsq2 <= ACSQ_W'(r_ac1 * r_ac1);
            r_eisq2 <= ETASQ_W'(r_ei1 * r_ei1);
            r_etsq2 <= ETASQ_W'(r_et1 * r_et1);
            r_ac2   <= r_ac1;
            r_ei2   <= r_ei1;
            r_lhs3  <= LHS_W'(r_eisq2 * w_s2);
            r_etsq3 <= r_etsq2;
            r_ac3   <= r_ac2;
            r_ei3   <= r_ei2;
            r_tir4  <= w_tir;
            r_rad4  <= w_tir ? '0 : RAD_W'(w_rhs - r_lhs3);
            r_sa4   <= SA_W'(r_etsq3 * r_ac3);
            r_pa4   <= PA_W'(r_ei3 * r_ac3);
            r_ei4   <= r_ei3;
        end
    end

    // square root chain, one result bit per cell
    logic                   w_sq_v    [ROOT_W+1];
    logic [RAD_W-1:0]       w_sq_rad  [ROOT_W+1];
    logic [REM_W-1:0]       w_sq_rem  [ROOT_W+1];
    logic [ROOT_W-1:0]      w_sq_root [ROOT_W+1];
    logic [SQRT_SIDE_W-1:0] w_sq_side [ROOT_W+1];

    assign w_sq_v[0]    = r_v4;
    assign w_sq_rad[0]  = r_rad4;
    assign w_sq_rem[0]  = '0;
    assign w_sq_root[0] = '0;
    assign w_sq_side[0] = {r_tir4, r_ei4, r_sa4, r_pa4};

    for (genvar g = 0; g < ROOT_W; g++) begin : g_sqrt
        fdr_sqrt_cell #(.K(ROOT_W-1-g), .SW(SQRT_SIDE_W)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_valid (w_sq_v[g]),
            .i_rad   (w_sq_rad[g]),
            .i_rem   (w_sq_rem[g]),
            .i_root  (w_sq_root[g]),
            .i_side  (w_sq_side[g]),
            .o_valid (w_sq_v[g+1]),
            .o_rad   (w_sq_rad[g+1]),
            .o_rem   (w_sq_rem[g+1]),
            .o_root  (w_sq_root[g+1]),
            .o_side  (w_sq_side[g+1])
        );
    end

    logic [ROOT_W-1:0] w_q;
    logic              w_tir_q;
    logic [ETA_W-1:0]  w_ei_q;
    logic [SA_W-1:0]   w_sa_q;
    logic [PA_W-1:0]   w_pa_q;

    assign w_q = w_sq_root[ROOT_W];
    assign {w_tir_q, w_ei_q, w_sa_q, w_pa_q} = w_sq_side[ROOT_W];

    // ratio operands
    logic              r_tir5, r_tir6;
    logic [SA_W-1:0]   r_sa5, r_sb5;
    logic [PA_W-1:0]   r_pa5, r_pb5;
    logic [SN_W-1:0]   r_sn6;
    logic [SD_W-1:0]   r_sd6;
    logic [PN_W-1:0]   r_pn6;
    logic [PD_W-1:0]   r_pd6;
    logic              r_zs6, r_zp6;
    logic [SD_W-1:0]   w_sd;
    logic [SA_W-1:0]   w_sn;
    logic [PD_W-1:0]   w_pd;
    logic [PA_W-1:0]   w_pn;

    always_comb begin
        w_sd = SD_W'(r_sa5) + SD_W'(r_sb5);
        w_sn = (r_sa5 >= r_sb5) ? (r_sa5 - r_sb5) : (r_sb5 - r_sa5);
        w_pd = PD_W'(r_pa5) + PD_W'(r_pb5);
        w_pn = (r_pa5 >= r_pb5) ? (r_pa5 - r_pb5) : (r_pb5 - r_pa5);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v5 <= 1'b0;
            r_v6 <= 1'b0;
        end else if (w_en) begin
            r_v5 <= w_sq_v[ROOT_W];
            r_v6 <= r_v5;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_tir5 <= w_tir_q;
            r_sa5  <= w_sa_q;
            r_sb5  <= SA_W'(w_ei_q * w_q);
            r_pa5  <= w_pa_q;
            r_pb5  <= w_q;
            r_tir6 <= r_tir5;
            r_sn6  <= (SN_W'(w_sn) << FRAC_SH) + SN_W'(w_sd >> 1);
            r_sd6  <= w_sd;
            r_zs6  <= w_sd == '0;
            r_pn6  <= (PN_W'(w_pn) << FRAC_SH) + PN_W'(w_pd >> 1);
            r_pd6  <= w_pd;
            r_zp6  <= w_pd == '0;
        end
    end

    // divider chains, s and p in parallel
    logic              w_ds_v    [Q_W+1];
    logic [SN_W-1:0]   w_ds_num  [Q_W+1];
    logic [SD_W-1:0]   w_ds_den  [Q_W+1];
    logic [Q_W-1:0]    w_ds_quo  [Q_W+1];
    logic [1:0]        w_ds_side [Q_W+1];
    logic              w_dp_v    [Q_W+1];
    logic [PN_W-1:0]   w_dp_num  [Q_W+1];
    logic [PD_W-1:0]   w_dp_den  [Q_W+1];
    logic [Q_W-1:0]    w_dp_quo  [Q_W+1];
    logic              w_dp_side [Q_W+1];

    assign w_ds_v[0]    = r_v6;
    assign w_ds_num[0]  = r_sn6;
    assign w_ds_den[0]  = r_sd6;
    assign w_ds_quo[0]  = '0;
    assign w_ds_side[0] = {r_tir6, r_zs6};
    assign w_dp_v[0]    = r_v6;
    assign w_dp_num[0]  = r_pn6;
    assign w_dp_den[0]  = r_pd6;
    assign w_dp_quo[0]  = '0;
    assign w_dp_side[0] = r_zp6;

    for (genvar g = 0; g < Q_W; g++) begin : g_div
        fdr_div_cell #(.K(Q_W-1-g), .NW(SN_W), .DW(SD_W), .SW(2)) u_s (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_valid (w_ds_v[g]),
            .i_num   (w_ds_num[g]),
            .i_den   (w_ds_den[g]),
            .i_quo   (w_ds_quo[g]),
            .i_side  (w_ds_side[g]),
            .o_valid (w_ds_v[g+1]),
            .o_num   (w_ds_num[g+1]),
            .o_den   (w_ds_den[g+1]),
            .o_quo   (w_ds_quo[g+1]),
            .o_side  (w_ds_side[g+1])
        );
        fdr_div_cell #(.K(Q_W-1-g), .NW(PN_W), .DW(PD_W), .SW(1)) u_p (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_valid (w_dp_v[g]),
            .i_num   (w_dp_num[g]),
            .i_den   (w_dp_den[g]),
            .i_quo   (w_dp_quo[g]),
            .i_side  (w_dp_side[g]),
            .o_valid (w_dp_v[g+1]),
            .o_num   (w_dp_num[g+1]),
            .o_den   (w_dp_den[g+1]),
            .o_quo   (w_dp_quo[g+1]),
            .o_side  (w_dp_side[g+1])
        );
    end

    // squares and final sum
    logic              r_tir7;
    logic [RSQ_W-1:0]  r_rs7, r_rp7;
    logic [Q_W-1:0]    w_rs, w_rp;
    logic [SUM_W-1:0]  w_sum;
    logic [SUM_W-1:0]  w_res;
    logic [REFL_W-1:0] w_refl;

    always_comb begin
        // zero denominator counts as a ratio of one
        w_rs  = w_ds_side[Q_W][0] ? RATIO_ONE : w_ds_quo[Q_W];
        w_rp  = w_dp_side[Q_W]    ? RATIO_ONE : w_dp_quo[Q_W];
        w_sum = SUM_W'(r_rs7) + SUM_W'(r_rp7) + (SUM_W'(1) << (SQ_SH - 1));
        w_res = w_sum >> SQ_SH;
        if (r_tir7 || w_res > SUM_W'(ONE_Q15)) begin
            w_refl = ONE_Q15;
        end else begin
            w_refl = REFL_W'(w_res);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v7 <= 1'b0;
        end else if (w_en) begin
            r_v7 <= w_ds_v[Q_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_tir7 <= w_ds_side[Q_W][1];
            r_rs7  <= RSQ_W'(w_rs * w_rs);
            r_rp7  <= RSQ_W'(w_rp * w_rp);
        end
    end

    // two-beat output buffer
    logic [1:0]        r_cnt;
    logic [REFL_W-1:0] r_buf0, r_buf1;

    assign w_pop  = o_out.valid && o_out.ready;
    assign w_en   = (r_cnt != 2'd2) || w_pop;
    assign w_push = w_en && r_v7;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= r_cnt + 2'(w_push) - 2'(w_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_pop) begin
            r_buf0 <= (r_cnt == 2'd2) ? r_buf1 : w_refl;
        end else if (w_push && r_cnt == 2'd0) begin
            r_buf0 <= w_refl;
        end
        if (w_push && ((r_cnt == 2'd1 && !w_pop) || (r_cnt == 2'd2))) begin
            r_buf1 <= w_refl;
        end
    end

    assign i_in.ready        = w_en;
    assign o_out.valid       = r_cnt != 2'd0;
    assign o_out.reflectance = r_buf0;
endmodule

### rtl/fdr_sqrt_cell.sv
// one digit cell of the integer square root chain
// depends on fdr_pkg
module fdr_sqrt_cell #(
    parameter int K  = 0,
    parameter int SW = 1
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_en,
    input  logic                         i_valid,
    input  logic [fdr_pkg::RAD_W-1:0]    i_rad,
    input  logic [fdr_pkg::REM_W-1:0]    i_rem,
    input  logic [fdr_pkg::ROOT_W-1:0]   i_root,
    input  logic [SW-1:0]                i_side,
    output logic                         o_valid,
    output logic [fdr_pkg::RAD_W-1:0]    o_rad,
    output logic [fdr_pkg::REM_W-1:0]    o_rem,
    output logic [fdr_pkg::ROOT_W-1:0]   o_root,
    output logic [SW-1:0]                o_side
);
    import fdr_pkg::*;

    logic                r_valid;
    logic [RAD_W-1:0]    r_rad;
    logic [REM_W-1:0]    r_rem;
    logic [ROOT_W-1:0]   r_root;
    logic [SW-1:0]       r_side;
    logic [REM_W+1:0]    w_rem_x;
    logic [REM_W+1:0]    w_trial;
    logic                w_ge;

    always_comb begin
        w_rem_x = {i_rem, i_rad[2*K+1 -: 2]};
        w_trial = (REM_W+2)'({i_root, 2'b01});
        w_ge    = w_rem_x >= w_trial;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rad  <= i_rad;
            r_rem  <= w_ge ? REM_W'(w_rem_x - w_trial) : REM_W'(w_rem_x);
            r_root <= {i_root[ROOT_W-2:0], w_ge};
            r_side <= i_side;
        end
    end

    assign o_valid = r_valid;
    assign o_rad   = r_rad;
    assign o_rem   = r_rem;
    assign o_root  = r_root;
    assign o_side  = r_side;
endmodule

### rtl/fdr_div_cell.sv
// one quotient bit cell of the restoring divider chain
// depends on fdr_pkg
module fdr_div_cell #(
    parameter int K  = 0,
    parameter int NW = 46,
    parameter int DW = 29,
    parameter int SW = 1
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_en,
    input  logic                       i_valid,
    input  logic [NW-1:0]              i_num,
    input  logic [DW-1:0]              i_den,
    input  logic [fdr_pkg::Q_W-1:0]    i_quo,
    input  logic [SW-1:0]              i_side,
    output logic                       o_valid,
    output logic [NW-1:0]              o_num,
    output logic [DW-1:0]              o_den,
    output logic [fdr_pkg::Q_W-1:0]    o_quo,
    output logic [SW-1:0]              o_side
);
    import fdr_pkg::*;

    logic              r_valid;
    logic [NW-1:0]     r_num;
    logic [DW-1:0]     r_den;
    logic [Q_W-1:0]    r_quo;
    logic [SW-1:0]     r_side;
    logic [NW-1:0]     w_trial;
    logic              w_ge;

    always_comb begin
        w_trial = NW'(i_den) << K;
        w_ge    = i_num >= w_trial;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_num  <= w_ge ? (i_num - w_trial) : i_num;
            r_den  <= i_den;
            r_quo  <= {i_quo[Q_W-2:0], w_ge};
            r_side <= i_side;
        end
    end

    assign o_valid = r_valid;
    assign o_num   = r_num;
    assign o_den   = r_den;
    assign o_quo   = r_quo;
    assign o_side  = r_side;
endmodule
